// File: rtl/tlfk_pkg.sv
`default_nettype none
package tlfk_pkg;
	localparam int CountW = 24;
	localparam int ScaleW = 32;
	localparam int PosW = 26;
	localparam int ZW = 32;
	localparam int NumRegs = 8;
	localparam int AddrW = 5;
	localparam int AtanEntries = 30;
	localparam logic [31:0] GainQ32 = 32'd2608131496;
	localparam logic [31:0] QuarterTurn = 32'h4000_0000;

	typedef enum logic [2:0] {
		REG_ZERO_J1 = 3'd0,
		REG_ZERO_J2 = 3'd1,
		REG_ZERO_J3 = 3'd2,
		REG_ZERO_J4 = 3'd3,
		REG_APC_J1  = 3'd4,
		REG_APC_J2  = 3'd5,
		REG_HPC_J3  = 3'd6,
		REG_HPC_J4  = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [CountW-1:0] count_j1;
		logic signed [CountW-1:0] count_j2;
		logic signed [CountW-1:0] count_j3;
		logic signed [CountW-1:0] count_j4;
	} joint_item_t;

	typedef struct packed {
		logic signed [PosW-1:0] pos_x;
		logic signed [PosW-1:0] pos_y;
		logic signed [ZW-1:0]   pos_z;
		logic                   z_saturated;
	} pos_item_t;

	typedef struct packed {
		logic signed [CountW-1:0] zero_j1;
		logic signed [CountW-1:0] zero_j2;
		logic signed [CountW-1:0] zero_j3;
		logic signed [CountW-1:0] zero_j4;
		logic signed [ScaleW-1:0] apc_j1;
		logic signed [ScaleW-1:0] apc_j2;
		logic signed [ScaleW-1:0] hpc_j3;
		logic signed [ScaleW-1:0] hpc_j4;
	} cfg_regs_t;

	function automatic logic [31:0] atan_turn(input int i);
		logic [31:0] t;
		case (i)
			0: t = 32'h20000000; 1: t = 32'h12E4051E; 2: t = 32'h09FB385B;
			3: t = 32'h051111D4; 4: t = 32'h028B0D43; 5: t = 32'h0145D7E1;
			6: t = 32'h00A2F61E; 7: t = 32'h00517C55; 8: t = 32'h0028BE53;
			9: t = 32'h00145F2F; 10: t = 32'h000A2F98; 11: t = 32'h000517CC;
			12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2F9;
			15: t = 32'h0000517C; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
			18: t = 32'h00000A2F; 19: t = 32'h00000517; 20: t = 32'h0000028B;
			21: t = 32'h00000145; 22: t = 32'h000000A2; 23: t = 32'h00000051;
			24: t = 32'h00000028; 25: t = 32'h00000014; 26: t = 32'h0000000A;
			27: t = 32'h00000005; 28: t = 32'h00000002; 29: t = 32'h00000001;
			default: t = 32'h0;
		endcase
		return t;
	endfunction
endpackage
`default_nettype wire

// File: rtl/tlfk_stream_if.sv
`default_nettype none
interface tlfk_stream_if #(parameter int W = 8);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/tlfk_cordic.sv
`default_nettype none
// Pipelined rotation CORDIC, one stage per register; scales by length.
module tlfk_cordic #(
	parameter int STAGES = 24,
	parameter int LEN = 225,
	parameter int TW = 8
) (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic [31:0]        angle,
	input  wire logic [TW-1:0]      tag_in,
	output      logic signed [47:0] cos_out,
	output      logic signed [47:0] sin_out,
	output      logic [TW-1:0]      tag_out
);
	localparam int N = (STAGES < tlfk_pkg::AtanEntries) ? STAGES : tlfk_pkg::AtanEntries;
	localparam logic signed [47:0] X0 = 48'(longint'(LEN) * longint'(tlfk_pkg::GainQ32));

	logic signed [47:0] x_s [N+1];
	logic signed [47:0] y_s [N+1];
	logic signed [32:0] z_s [N+1];
	logic               f_s [N+1];
	logic [TW-1:0]      t_s [N+1];
	logic               flip;
	logic [31:0]        r;

	assign flip = angle[31] ^ angle[30];
	assign r = flip ? (angle ^ 32'h8000_0000) : angle;

	// Fold into the right half plane on entry.
	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= X0;
			y_s[0] <= '0;
			z_s[0] <= {r[31], r};
			f_s[0] <= flip;
			t_s[0] <= tag_in;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_st
		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_s[i][32]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - $signed({1'b0, tlfk_pkg::atan_turn(i)});
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + $signed({1'b0, tlfk_pkg::atan_turn(i)});
				end
				f_s[i+1] <= f_s[i];
				t_s[i+1] <= t_s[i];
			end
		end
	end

	assign cos_out = f_s[N] ? -x_s[N] : x_s[N];
	assign sin_out = f_s[N] ? -y_s[N] : y_s[N];
	assign tag_out = t_s[N];
endmodule
`default_nettype wire

// File: rtl/two_link_arm_forward_kinematics.sv
// Pipeline: s1, s2, s3, the CORDIC registers and the output register lie between input accept and output valid.
// Throughput: one item per cycle; the whole pipe advances when the output
// register is empty or being taken, so a stall holds every stage in place.
// Reset (arst_n low, asynchronous): valid bits clear and the registers load
// their defaults (zero counts 1791, 1884, 114, -66176; scales zero).
`default_nettype none
module two_link_arm_forward_kinematics #(
	parameter int LINK1_LENGTH_MM = 225,
	parameter int LINK2_LENGTH_MM = 125,
	parameter int CORDIC_STAGES = 24
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	tlfk_stream_if.sink                     joints,
	tlfk_stream_if.source                   pos,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [tlfk_pkg::AddrW-1:0] paddr,
	input  wire logic [31:0]                pwdata,
	output      logic [31:0]                prdata,
	output      logic                       pready
);
	localparam int N = (CORDIC_STAGES < tlfk_pkg::AtanEntries) ?
		CORDIC_STAGES : tlfk_pkg::AtanEntries;
	// Stages: s1 subtract, s2 multiply, s3 add offsets, CORDIC N+1, out.
	localparam int ZDLY = N + 1;

	tlfk_pkg::cfg_regs_t cfg_q;
	tlfk_pkg::joint_item_t in_item;
	tlfk_pkg::pos_item_t out_q;
	logic out_valid_q;
	logic en;
	logic [2:0] widx;

	assign in_item = joints.data;
	assign pready = 1'b1;
	assign widx = paddr[4:2];

	// Configuration writes land on the access cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.zero_j1 <= 24'sd1791;
			cfg_q.zero_j2 <= 24'sd1884;
			cfg_q.zero_j3 <= 24'sd114;
			cfg_q.zero_j4 <= -24'sd66176;
			cfg_q.apc_j1 <= '0;
			cfg_q.apc_j2 <= '0;
			cfg_q.hpc_j3 <= '0;
			cfg_q.hpc_j4 <= '0;
		end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
			unique case (tlfk_pkg::reg_idx_t'(widx))
				tlfk_pkg::REG_ZERO_J1: cfg_q.zero_j1 <= pwdata[23:0];
				tlfk_pkg::REG_ZERO_J2: cfg_q.zero_j2 <= pwdata[23:0];
				tlfk_pkg::REG_ZERO_J3: cfg_q.zero_j3 <= pwdata[23:0];
				tlfk_pkg::REG_ZERO_J4: cfg_q.zero_j4 <= pwdata[23:0];
				tlfk_pkg::REG_APC_J1:  cfg_q.apc_j1 <= pwdata;
				tlfk_pkg::REG_APC_J2:  cfg_q.apc_j2 <= pwdata;
				tlfk_pkg::REG_HPC_J3:  cfg_q.hpc_j3 <= pwdata;
				tlfk_pkg::REG_HPC_J4:  cfg_q.hpc_j4 <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[1:0] == 2'b00) begin
			unique case (tlfk_pkg::reg_idx_t'(widx))
				tlfk_pkg::REG_ZERO_J1: prdata = 32'(cfg_q.zero_j1);
				tlfk_pkg::REG_ZERO_J2: prdata = 32'(cfg_q.zero_j2);
				tlfk_pkg::REG_ZERO_J3: prdata = 32'(cfg_q.zero_j3);
				tlfk_pkg::REG_ZERO_J4: prdata = 32'(cfg_q.zero_j4);
				tlfk_pkg::REG_APC_J1:  prdata = cfg_q.apc_j1;
				tlfk_pkg::REG_APC_J2:  prdata = cfg_q.apc_j2;
				tlfk_pkg::REG_HPC_J3:  prdata = cfg_q.hpc_j3;
				tlfk_pkg::REG_HPC_J4:  prdata = cfg_q.hpc_j4;
				default: prdata = '0;
			endcase
		end
	end

	// Global stall: advance when output slot is free or being taken.
	assign en = !out_valid_q || pos.ready;
	assign joints.ready = en;

	// Valid shift line spans s1..s3 plus the CORDIC depth.
	localparam int VD = 3 + N + 1;
	logic [VD-1:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[VD-2:0], joints.valid};
	end

	// s1: subtract zero counts.
	logic signed [24:0] d1_s1, d2_s1, d3_s1, d4_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			d1_s1 <= 25'(in_item.count_j1) - 25'(cfg_q.zero_j1);
			d2_s1 <= 25'(in_item.count_j2) - 25'(cfg_q.zero_j2);
			d3_s1 <= 25'(in_item.count_j3) - 25'(cfg_q.zero_j3);
			d4_s1 <= 25'(in_item.count_j4) - 25'(cfg_q.zero_j4);
		end
	end

	// s2: one multiply per joint.
	logic [31:0] a1_s2, a2_s2;
	logic signed [56:0] h3_s2, h4_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			a1_s2 <= 32'(d1_s1 * cfg_q.apc_j1);
			a2_s2 <= 32'(d2_s1 * cfg_q.apc_j2);
			h3_s2 <= 57'(d3_s1 * cfg_q.hpc_j3);
			h4_s2 <= 57'(d4_s1 * cfg_q.hpc_j4);
		end
	end

	// s3: quarter-turn offset, angle sum, height difference with rounding.
	logic [31:0] a1_s3, a12_s3;
	logic signed [57:0] zr_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			a1_s3 <= a1_s2 + tlfk_pkg::QuarterTurn;
			a12_s3 <= a1_s2 + tlfk_pkg::QuarterTurn + a2_s2;
			zr_s3 <= 58'(h4_s2) - 58'(h3_s2) + 58'sd128;
		end
	end

	// z waits alongside the CORDIC pipe.
	logic signed [57:0] zd_q [ZDLY];
	always_ff @(posedge clk) begin
		if (en) begin
			zd_q[0] <= zr_s3;
			for (int i = 1; i < ZDLY; i++) zd_q[i] <= zd_q[i-1];
		end
	end

	logic signed [47:0] c1, s1, c12, s12;
	logic u1, u2;
	tlfk_cordic #(.STAGES(CORDIC_STAGES), .LEN(LINK1_LENGTH_MM), .TW(1)) u_cordic1 (
		.clk(clk), .en(en), .angle(a1_s3), .tag_in(1'b0),
		.cos_out(c1), .sin_out(s1), .tag_out(u1));
	tlfk_cordic #(.STAGES(CORDIC_STAGES), .LEN(LINK2_LENGTH_MM), .TW(1)) u_cordic2 (
		.clk(clk), .en(en), .angle(a12_s3), .tag_in(u1),
		.cos_out(c12), .sin_out(s12), .tag_out(u2));

	// Output stage: sum, round to Q16, clamp.
	logic signed [48:0] xs, ys;
	logic signed [49:0] zs;
	tlfk_pkg::pos_item_t res;
	localparam logic signed [48:0] PMax = 49'sd33554431;
	localparam logic signed [48:0] PMin = -49'sd33554432;
	always_comb begin
		xs = (49'(c1) + 49'(c12) + 49'sd32768) >>> 16;
		ys = (49'(s1) + 49'(s12) + 49'sd32768) >>> 16;
		zs = 50'(zd_q[ZDLY-1] >>> 8);
		res.pos_x = (xs > PMax) ? 26'(PMax) : (xs < PMin) ? 26'(PMin) : 26'(xs);
		res.pos_y = (ys > PMax) ? 26'(PMax) : (ys < PMin) ? 26'(PMin) : 26'(ys);
		res.z_saturated = 1'b1;
		if (zs > 50'sd2147483647) res.pos_z = 32'h7FFF_FFFF;
		else if (zs < -50'sd2147483648) res.pos_z = 32'h8000_0000;
		else begin
			res.pos_z = 32'(zs);
			res.z_saturated = u2 & 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (en) out_valid_q <= vld_q[VD-1];
	end
	always_ff @(posedge clk) begin
		if (en) out_q <= res;
	end

	assign pos.valid = out_valid_q;
	assign pos.data = out_q;
endmodule
`default_nettype wire

// File: rtl/tlfk_checker.sv
`default_nettype none
module tlfk_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [84:0] out_data
);
	// Stalled output holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output changed under stall");
	// Input side freezes exactly when output stalls.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("ready does not follow output stall");
	// Saturation flag implies z at a rail.
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data[0] |->
		(out_data[32:1] == 32'h7FFF_FFFF || out_data[32:1] == 32'h8000_0000))
		else $error("saturation flag without clamped z");
endmodule

bind two_link_arm_forward_kinematics tlfk_checker u_tlfk_checker (
	.clk(clk), .arst_n(arst_n),
	.in_valid(joints.valid), .in_ready(joints.ready),
	.out_valid(pos.valid), .out_ready(pos.ready), .out_data(pos.data));
`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 1ps

class arm_pose_scoreboard;
	tlfk_pkg::cfg_regs_t cfg;
	tlfk_pkg::pos_item_t pending_pos[$];
	int unsigned mismatches;

	localparam longint GAIN = 64'd2608131496;
	logic [31:0] arc [30] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
		32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
		32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001};

	function new();
		cfg = '0;
		cfg.zero_j1 = 24'sd1791;
		cfg.zero_j2 = 24'sd1884;
		cfg.zero_j3 = 24'sd114;
		cfg.zero_j4 = -24'sd66176;
		mismatches = 0;
	endfunction

	function void write_reg(tlfk_pkg::reg_idx_t idx, logic [31:0] v);
		case (idx)
			tlfk_pkg::REG_ZERO_J1: cfg.zero_j1 = v[23:0];
			tlfk_pkg::REG_ZERO_J2: cfg.zero_j2 = v[23:0];
			tlfk_pkg::REG_ZERO_J3: cfg.zero_j3 = v[23:0];
			tlfk_pkg::REG_ZERO_J4: cfg.zero_j4 = v[23:0];
			tlfk_pkg::REG_APC_J1:  cfg.apc_j1 = v;
			tlfk_pkg::REG_APC_J2:  cfg.apc_j2 = v;
			tlfk_pkg::REG_HPC_J3:  cfg.hpc_j3 = v;
			tlfk_pkg::REG_HPC_J4:  cfg.hpc_j4 = v;
		endcase
	endfunction

	// len * (cos, sin) of a binary angle, Q32 mm
	function void rotate(logic [31:0] a, longint len, output longint cx, output longint sy);
		logic        flip;
		logic [31:0] r;
		longint      x, y, z, dx, dy;
		flip = (a[31:30] == 2'b01) || (a[31:30] == 2'b10);
		r = flip ? (a ^ 32'h8000_0000) : a;
		z = longint'($signed(r));
		x = len * GAIN;
		y = 0;
		for (int i = 0; i < 24 && i < 30; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(arc[i]);
			end else begin
				x += dx; y -= dy; z += longint'(arc[i]);
			end
		end
		cx = flip ? -x : x;
		sy = flip ? -y : y;
	endfunction

	function void note(tlfk_pkg::joint_item_t j);
		longint              p1, p2, c1, s1, c12, s12, xs, ys, h3, h4, zs;
		logic [31:0]         a1, a2;
		tlfk_pkg::pos_item_t e;
		p1 = (longint'(j.count_j1) - longint'(cfg.zero_j1)) * longint'(cfg.apc_j1);
		p2 = (longint'(j.count_j2) - longint'(cfg.zero_j2)) * longint'(cfg.apc_j2);
		a1 = p1[31:0] + 32'h4000_0000;
		a2 = p2[31:0];
		rotate(a1, 225, c1, s1);
		rotate(a1 + a2, 125, c12, s12);
		xs = (c1 + c12 + 32768) >>> 16;
		ys = (s1 + s12 + 32768) >>> 16;
		if (xs < -(64'sd1 <<< 25)) xs = -(64'sd1 <<< 25);
		if (xs > (64'sd1 <<< 25) - 1) xs = (64'sd1 <<< 25) - 1;
		if (ys < -(64'sd1 <<< 25)) ys = -(64'sd1 <<< 25);
		if (ys > (64'sd1 <<< 25) - 1) ys = (64'sd1 <<< 25) - 1;
		h3 = (longint'(j.count_j3) - longint'(cfg.zero_j3)) * longint'(cfg.hpc_j3);
		h4 = (longint'(j.count_j4) - longint'(cfg.zero_j4)) * longint'(cfg.hpc_j4);
		zs = (h4 - h3 + 128) >>> 8;
		e.z_saturated = 1'b0;
		if (zs > 64'sd2147483647) begin
			zs = 64'sd2147483647; e.z_saturated = 1'b1;
		end else if (zs < -64'sd2147483648) begin
			zs = -64'sd2147483648; e.z_saturated = 1'b1;
		end
		e.pos_x = xs[25:0];
		e.pos_y = ys[25:0];
		e.pos_z = zs[31:0];
		pending_pos.push_back(e);
	endfunction

	function void check(tlfk_pkg::pos_item_t got);
		tlfk_pkg::pos_item_t e;
		if (pending_pos.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("unexpected pose item %h", got);
			return;
		end
		e = pending_pos.pop_front();
		if (got.pos_x !== e.pos_x || got.pos_y !== e.pos_y || got.pos_z !== e.pos_z ||
				got.z_saturated !== e.z_saturated) begin
			mismatches++;
			if (mismatches <= 10)
				$display("pose mismatch: exp x=%0d y=%0d z=%0d sat=%0b got x=%0d y=%0d z=%0d sat=%0b",
					e.pos_x, e.pos_y, e.pos_z, e.z_saturated,
					got.pos_x, got.pos_y, got.pos_z, got.z_saturated);
		end
	endfunction
endclass

module tb;
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	tlfk_stream_if #(.W($bits(tlfk_pkg::joint_item_t))) joints_if();
	tlfk_stream_if #(.W($bits(tlfk_pkg::pos_item_t)))   pos_if();

	arm_pose_scoreboard sb = new();
	int burst_left = 0;

	two_link_arm_forward_kinematics u_dut (
		.clk(clk), .arst_n(arst_n),
		.joints(joints_if), .pos(pos_if),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	// check every pose item the block hands over
	always @(posedge clk)
		if (arst_n && pos_if.valid && pos_if.ready) sb.check(pos_if.data);

	// receiver: pick a random stall mode for each stretch, including stall-free stretches
	initial begin
		int mode;
		pos_if.ready = 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			for (int c = 0; c < 64; c++) begin
				@(negedge clk);
				case (mode)
					0: pos_if.ready = 1'b1;
					1: pos_if.ready = 1'($urandom_range(0, 1));
					2: pos_if.ready = (c % 8) < 5;
					default: pos_if.ready = $urandom_range(0, 9) < 2;
				endcase
			end
		end
	end

	// write one register over APB: setup, then access
	task automatic write_reg(tlfk_pkg::reg_idx_t idx, logic [31:0] v);
		@(negedge clk);
		psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
		paddr = {idx, 2'b00}; pwdata = v;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		sb.write_reg(idx, v);
		@(negedge clk);
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
	endtask

	// hand over one joint sample; bursts of random length with random gaps
	task automatic send_joints(tlfk_pkg::joint_item_t j);
		if (burst_left == 0) begin
			int gap;
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
			@(negedge clk);
			joints_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
			burst_left = $urandom_range(1, 24);
		end else
			@(negedge clk);
		burst_left--;
		joints_if.valid = 1'b1;
		joints_if.data = j;
		do @(posedge clk); while (!joints_if.ready);
		sb.note(j);
	endtask

	// drop valid and wait for the pipe to drain before touching registers
	task automatic drain();
		@(negedge clk);
		joints_if.valid = 1'b0;
		burst_left = 0;
		while (sb.pending_pos.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic logic [23:0] pick_count(int k, logic [23:0] zero);
		logic [31:0] r;
		r = $urandom();
		case (k & 3)
			0: return r[23:0];
			1: return zero + 24'(r[7:0]) - 24'd128;
			2: return r[31] ? 24'h800000 + 24'(r[3:0]) : 24'h7FFFFF - 24'(r[3:0]);
			default: return zero + 24'(r[19:0]) - 24'h80000;
		endcase
	endfunction

	function automatic logic [23:0] edge_count(int k);
		case (k & 3)
			0: return 24'h800000;
			1: return 24'h7FFFFF;
			2: return 24'h000000;
			default: return 24'hFFFFFF;
		endcase
	endfunction

	task automatic directed_items();
		tlfk_pkg::joint_item_t j;
		for (int i = 0; i < 16; i++) begin
			j.count_j1 = edge_count(i);
			j.count_j2 = edge_count(i >> 2);
			j.count_j3 = edge_count(i + 1);
			j.count_j4 = edge_count((i >> 2) + 2);
			send_joints(j);
		end
		// every joint exactly at its zero count
		j.count_j1 = sb.cfg.zero_j1;
		j.count_j2 = sb.cfg.zero_j2;
		j.count_j3 = sb.cfg.zero_j3;
		j.count_j4 = sb.cfg.zero_j4;
		send_joints(j);
	endtask

	task automatic random_items(int n);
		tlfk_pkg::joint_item_t j;
		int k;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 15);
			j.count_j1 = pick_count(k, sb.cfg.zero_j1);
			j.count_j2 = pick_count(k >> 1, sb.cfg.zero_j2);
			j.count_j3 = pick_count(k >> 2, sb.cfg.zero_j3);
			j.count_j4 = pick_count($urandom_range(0, 3), sb.cfg.zero_j4);
			send_joints(j);
		end
	endtask

	initial begin
		joints_if.valid = 1'b0;
		joints_if.data = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset defaults: scales are zero, arm points along y
		directed_items();
		random_items(150);

		for (int phase = 1; phase < 7; phase++) begin
			drain();
			case (phase)
				1: begin
					// plausible resolutions, lead folded into joint 4
					write_reg(tlfk_pkg::REG_ZERO_J1, 32'd1791);
					write_reg(tlfk_pkg::REG_ZERO_J2, 32'd1884);
					write_reg(tlfk_pkg::REG_ZERO_J3, 32'd114);
					write_reg(tlfk_pkg::REG_ZERO_J4, -32'sd66176);
					write_reg(tlfk_pkg::REG_APC_J1, 32'd39049);
					write_reg(tlfk_pkg::REG_APC_J2, -32'sd40363);
					write_reg(tlfk_pkg::REG_HPC_J3, 32'd2043);
					write_reg(tlfk_pkg::REG_HPC_J4, -32'sd3055);
				end
				2: begin
					write_reg(tlfk_pkg::REG_ZERO_J1, 32'hFF80_0000);
					write_reg(tlfk_pkg::REG_ZERO_J2, 32'h007F_FFFF);
					write_reg(tlfk_pkg::REG_ZERO_J3, 32'hFF80_0000);
					write_reg(tlfk_pkg::REG_ZERO_J4, 32'h007F_FFFF);
					write_reg(tlfk_pkg::REG_APC_J1, 32'h8000_0000);
					write_reg(tlfk_pkg::REG_APC_J2, 32'h7FFF_FFFF);
					write_reg(tlfk_pkg::REG_HPC_J3, 32'h8000_0000);
					write_reg(tlfk_pkg::REG_HPC_J4, 32'h7FFF_FFFF);
				end
				3: begin
					write_reg(tlfk_pkg::REG_ZERO_J1, 32'h007F_FFFF);
					write_reg(tlfk_pkg::REG_ZERO_J2, 32'hFF80_0000);
					write_reg(tlfk_pkg::REG_ZERO_J3, 32'd0);
					write_reg(tlfk_pkg::REG_ZERO_J4, 32'd0);
					write_reg(tlfk_pkg::REG_APC_J1, 32'h7FFF_FFFF);
					write_reg(tlfk_pkg::REG_APC_J2, 32'h8000_0000);
					write_reg(tlfk_pkg::REG_HPC_J3, 32'h7FFF_FFFF);
					write_reg(tlfk_pkg::REG_HPC_J4, 32'h8000_0000);
				end
				default: begin
					for (int r = 0; r < 8; r++)
						write_reg(tlfk_pkg::reg_idx_t'(r), $urandom());
				end
			endcase
			if (phase == 2 || phase == 3) directed_items();
			random_items(phase >= 4 ? 170 : 150);
		end

		drain();
		if (sb.mismatches == 0 && sb.pending_pos.size() == 0)
			$display("two_link_arm_forward_kinematics regression: pass");
		else
			$display("two_link_arm_forward_kinematics regression: fail");
		$finish;
	end

	initial begin
		#2ms;
		$display("two_link_arm_forward_kinematics regression: fail");
		$finish;
	end
endmodule

// File: two_link_arm_forward_kinematics.f
rtl/tlfk_pkg.sv
rtl/tlfk_stream_if.sv
rtl/tlfk_cordic.sv
rtl/two_link_arm_forward_kinematics.sv
rtl/tlfk_checker.sv
verif/tb.sv
